// File: rtl/ttag_pkg.sv
// Shared types, constants and constant tables of the cadenced tone generator.
// The sine and fade tables are built at elaboration by integer Taylor series.
// No dependencies.
package ttag_pkg;

  // Table sizes.
  localparam int SINE_TABLE_DEPTH = 320;
  localparam int FADE_SAMPLES     = 24;
  localparam int HALF_FADE        = FADE_SAMPLES / 2;
  localparam int SINE_IW          = $clog2(SINE_TABLE_DEPTH);
  localparam int FADE_IW          = $clog2(FADE_SAMPLES + 1);
  localparam int HALF_IW          = $clog2(HALF_FADE + 1);

  // Cadence constants in samples.
  localparam logic [15:0] RING_CADENCE    = 16'd32000;
  localparam logic [15:0] RING_ON_SAMPLES = 16'd10400;
  localparam logic [15:0] RING_FADE_START = 16'(10400 - FADE_SAMPLES);
  localparam logic [15:0] RINGBACK_PERIOD = 16'd40000;
  localparam logic [15:0] RINGBACK_START  = 16'd16000;
  localparam logic [15:0] RINGBACK_END    = 16'd24000;
  localparam logic [8:0]  WARBLE_SAMPLES  = 9'd352;
  localparam logic [8:0]  WARBLE_HALF     = 9'd176;
  localparam logic [8:0]  WARBLE_END_FADE = 9'(352 - HALF_FADE);
  localparam logic [8:0]  WARBLE_MID_LO   = 9'(176 - HALF_FADE);
  localparam logic [8:0]  WARBLE_MID_HI   = 9'(176 + HALF_FADE);

  // Phase steps per sample for 1300 Hz and 425 Hz at 8 kHz.
  localparam logic [SINE_IW-1:0] RING_STEP     = SINE_IW'((1300 * SINE_TABLE_DEPTH) / 8000);
  localparam logic [SINE_IW-1:0] RINGBACK_STEP = SINE_IW'((425 * SINE_TABLE_DEPTH) / 8000);
  localparam logic [SINE_IW:0]   SINE_DEPTH_W  = (SINE_IW + 1)'(SINE_TABLE_DEPTH);

  // Envelope levels (Q1.16).
  localparam logic [16:0] ENV_ONE  = 17'h10000;
  localparam logic [16:0] ENV_HALF = 17'h08000;

  // A-law masks.
  localparam logic [7:0] ALAW_MASK_POS = 8'hD5;
  localparam logic [7:0] ALAW_MASK_NEG = 8'h55;
  localparam logic [7:0] ALAW_OVF      = 8'h7F;

  // Register map (index is paddr bit 2).
  localparam logic REG_TONE_KIND    = 1'b0;
  localparam logic REG_REVERSE_BITS = 1'b1;

  // Tone kinds.
  localparam logic TONE_RING     = 1'b0;
  localparam logic TONE_RINGBACK = 1'b1;

  typedef struct packed {
    logic tone_kind;
    logic reverse_bits;
  } ttag_cfg_t;

  typedef struct packed {
    logic load;        // take the input item and advance the counters
    logic env;         // sine read and envelope lookup
    logic mul_first;   // product of the two envelopes
    logic mul_second;  // sine times envelope product
    logic out_load;    // encode and load the output register
  } ttag_cmd_t;

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];
  typedef logic [16:0]        fade_tab_t [FADE_SAMPLES + 1];
  typedef logic [16:0]        half_tab_t [HALF_FADE + 1];

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          Q30_ONE = 64'sd1073741824;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};
  localparam int FADE_DEN = 4 * FADE_SAMPLES;
  localparam int HALF_DEN = 2 * FADE_SAMPLES;

  // Magnitude of sin(x) in Q30 for a Q30 angle x in [0, pi/2].
  function automatic longint sin_core(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > Q30_ONE) sum = Q30_ONE;
    return sum;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t       t;
    longint unsigned v;
    longint unsigned x;
    longint          m;
    logic            neg;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      v   = 64'(2 * (k % SINE_TABLE_DEPTH));
      neg = 1'b0;
      if (v >= 64'(SINE_TABLE_DEPTH)) begin
        neg = 1'b1;
        v   = v - 64'(SINE_TABLE_DEPTH);
      end
      if (2 * v > 64'(SINE_TABLE_DEPTH)) v = 64'(SINE_TABLE_DEPTH) - v;
      x = (PI_Q30 * v) / SINE_TABLE_DEPTH;
      m = (sin_core(x) + 16384) >>> 15;
      if (m > 32767) m = 32767;
      t[k] = neg ? -16'(m) : 16'(m);
    end
    return t;
  endfunction

  function automatic fade_tab_t build_fade();
    fade_tab_t       t;
    longint unsigned v;
    longint unsigned x;
    longint          c;
    logic            neg;
    for (int k = 0; k <= FADE_SAMPLES; k++) begin
      v   = 64'(2 * ((FADE_SAMPLES + 2 * k) % FADE_DEN));
      neg = 1'b0;
      if (v >= 64'(FADE_DEN)) begin
        neg = 1'b1;
        v   = v - 64'(FADE_DEN);
      end
      if (2 * v > 64'(FADE_DEN)) v = 64'(FADE_DEN) - v;
      x = (PI_Q30 * v) / FADE_DEN;
      c = sin_core(x);
      if (neg) c = -c;
      t[k] = 17'((Q30_ONE - c + 16384) >>> 15);
    end
    return t;
  endfunction

  function automatic half_tab_t build_half();
    half_tab_t       t;
    longint unsigned v;
    longint unsigned x;
    longint          s;
    for (int k = 0; k <= HALF_FADE; k++) begin
      v = 64'(2 * (k % HALF_DEN));
      if (2 * v > 64'(HALF_DEN)) v = 64'(HALF_DEN) - v;
      x = (PI_Q30 * v) / HALF_DEN;
      s = sin_core(x);
      t[k] = 17'((s + 16384) >>> 15);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam fade_tab_t FADE_TAB = build_fade();
  localparam half_tab_t HALF_TAB = build_half();

  localparam logic signed [17:0] SEG_TOP [8] = '{18'sh000FF, 18'sh001FF, 18'sh003FF,
                                                 18'sh007FF, 18'sh00FFF, 18'sh01FFF,
                                                 18'sh03FFF, 18'sh07FFF};

  // Ring cadence envelope with raised-cosine edges.
  function automatic logic [16:0] ring_env(logic [15:0] r);
    logic [15:0] d;
    logic [16:0] e;
    d = RING_ON_SAMPLES - r;
    if (r < 16'(FADE_SAMPLES)) e = FADE_TAB[r[FADE_IW-1:0]];
    else if (r > RING_FADE_START && r < RING_ON_SAMPLES) e = FADE_TAB[d[FADE_IW-1:0]];
    else if (r >= RING_ON_SAMPLES) e = '0;
    else e = ENV_ONE;
    return e;
  endfunction

  // Warble envelope: on in the first half, sine half-fades around each edge.
  function automatic logic [16:0] warble_env(logic [8:0] r);
    logic [8:0]  d_end;
    logic [8:0]  d_up;
    logic [8:0]  d_dn;
    logic [16:0] e;
    d_end = WARBLE_SAMPLES - r;
    d_up  = r - WARBLE_HALF;
    d_dn  = WARBLE_HALF - r;
    if (r > WARBLE_END_FADE) e = ENV_HALF - HALF_TAB[d_end[HALF_IW-1:0]];
    else if (r < 9'(HALF_FADE)) e = ENV_HALF + HALF_TAB[r[HALF_IW-1:0]];
    else if (r > WARBLE_MID_LO && r < WARBLE_MID_HI) begin
      if (r >= WARBLE_HALF) e = ENV_HALF - HALF_TAB[d_up[HALF_IW-1:0]];
      else e = ENV_HALF + HALF_TAB[d_dn[HALF_IW-1:0]];
    end else if (r <= WARBLE_HALF) e = ENV_ONE;
    else e = '0;
    return e;
  endfunction

  // A-law code of the linear value (idx - 128) * 256.
  function automatic logic [7:0] alaw_code(logic [7:0] idx);
    logic signed [17:0] v;
    logic [17:0]        vu;
    logic [7:0]         mask;
    logic [2:0]         seg;
    logic               hit;
    logic [3:0]         mant;
    logic [7:0]         code;
    v = $signed({({2'b00, idx} - 10'd128), 8'd0});
    if (v >= 0) mask = ALAW_MASK_POS;
    else begin
      mask = ALAW_MASK_NEG;
      v    = -v - 18'sd8;
    end
    seg = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && v <= SEG_TOP[i]) begin
        seg = 3'(i);
        hit = 1'b1;
      end
    end
    vu = v;
    if (seg < 3'd2) mant = vu[7:4];
    else mant = 4'(vu >> ({1'b0, seg} + 4'd3));
    if (!hit) code = ALAW_OVF ^ mask;
    else code = {1'b0, seg, mant} ^ mask;
    return code;
  endfunction

  function automatic logic [7:0] bit_rev8(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7 - i] = b[i];
    return r;
  endfunction

endpackage

// File: rtl/ttag_regs.sv
// Configuration registers of the tone generator behind an APB-style port.
// Depends on ttag_pkg for the register map and the configuration struct.
module ttag_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ttag_pkg::ttag_cfg_t cfg
);
  import ttag_pkg::*;

  logic tone_kind_r;
  logic reverse_bits_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_kind_r    <= TONE_RING;
      reverse_bits_r <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TONE_KIND:    tone_kind_r    <= pwdata[0];
        REG_REVERSE_BITS: reverse_bits_r <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TONE_KIND:    prdata = {31'd0, tone_kind_r};
      REG_REVERSE_BITS: prdata = {31'd0, reverse_bits_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.tone_kind    = tone_kind_r;
  assign cfg.reverse_bits = reverse_bits_r;

  // The low address bits take no part in decoding.
  logic unused_addr;
  assign unused_addr = ^{paddr[1:0], pwdata[31:1]};

endmodule

// File: rtl/ttag_datapath.sv
// Datapath of the tone generator: cadence counters, sine ROM, envelopes,
// one shared multiplier, A-law encoder and output register. Uses ttag_pkg.
module ttag_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ttag_pkg::ttag_cmd_t cmd,
  input  ttag_pkg::ttag_cfg_t cfg,
  input  logic                in_restart,
  output logic [7:0]          out_alaw_sample,
  output logic                out_tone_on
);
  import ttag_pkg::*;

  // Cadence state.
  logic [15:0]        cad_r;
  logic [8:0]         wrb_r;
  logic [SINE_IW-1:0] ph_r;

  // Per-item work registers.
  logic [15:0]        pos_r;
  logic [8:0]         wpos_r;
  logic [SINE_IW-1:0] phase_r;
  logic signed [15:0] s_r;
  logic [16:0]        e1_r;
  logic [16:0]        e2_r;
  logic               rb_on_r;
  logic signed [23:0] s255_r;
  logic [56:0]        prod_r;
  logic [7:0]         alaw_r;
  logic               on_r;

  // Position of the current sample after restart and range fixes.
  logic [15:0]        period;
  logic [SINE_IW-1:0] step;
  logic [15:0]        cad_cur;
  logic [8:0]         wrb_cur;
  logic [SINE_IW-1:0] ph_cur;
  logic [15:0]        pos;
  logic [8:0]         wpos;
  logic [SINE_IW-1:0] phase;
  logic [16:0]        pos_inc;
  logic [9:0]         wpos_inc;
  logic [SINE_IW:0]   ph_sum;
  logic [SINE_IW:0]   ph_fix;

  always_comb begin
    period  = (cfg.tone_kind == TONE_RINGBACK) ? RINGBACK_PERIOD : RING_CADENCE;
    step    = (cfg.tone_kind == TONE_RINGBACK) ? RINGBACK_STEP : RING_STEP;
    cad_cur = in_restart ? '0 : cad_r;
    wrb_cur = in_restart ? '0 : wrb_r;
    ph_cur  = in_restart ? '0 : ph_r;
    pos     = (cad_cur >= period) ? '0 : cad_cur;
    wpos    = (wrb_cur >= WARBLE_SAMPLES) ? '0 : wrb_cur;
    ph_fix  = {1'b0, ph_cur};
    phase   = (ph_fix >= SINE_DEPTH_W) ? SINE_IW'(ph_fix - SINE_DEPTH_W) : ph_cur;
    pos_inc  = {1'b0, pos} + 17'd1;
    wpos_inc = {1'b0, wpos} + 10'd1;
    ph_sum   = {1'b0, phase} + {1'b0, step};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cad_r <= '0;
      wrb_r <= '0;
      ph_r  <= '0;
    end else if (cmd.load) begin
      cad_r <= (pos_inc >= {1'b0, period}) ? '0 : pos_inc[15:0];
      wrb_r <= (wpos_inc >= {1'b0, WARBLE_SAMPLES}) ? '0 : wpos_inc[8:0];
      ph_r  <= (ph_sum >= SINE_DEPTH_W) ? SINE_IW'(ph_sum - SINE_DEPTH_W)
                                        : ph_sum[SINE_IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r   <= pos;
      wpos_r  <= wpos;
      phase_r <= phase;
    end
  end

  // Sine ROM with registered read, envelope lookups.
  always_ff @(posedge clk) begin
    if (cmd.env) begin
      s_r     <= SINE_TAB[phase_r];
      e1_r    <= ring_env(pos_r);
      e2_r    <= warble_env(wpos_r);
      rb_on_r <= (pos_r >= RINGBACK_START) && (pos_r < RINGBACK_END);
    end
  end

  // Shared multiplier: envelope product first, then sine*255 times it.
  logic signed [24:0] mul_a;
  logic [32:0]        mul_b;
  logic signed [58:0] mul_full;

  always_comb begin
    if (cmd.mul_second) begin
      mul_a = {s255_r[23], s255_r};
      mul_b = prod_r[32:0];
    end else begin
      mul_a = $signed({8'd0, e1_r});
      mul_b = {16'd0, e2_r};
    end
    mul_full = mul_a * $signed({1'b0, mul_b});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_first) s255_r <= $signed({s_r, 8'd0}) - 24'(s_r);
    if (cmd.mul_first || cmd.mul_second) prod_r <= mul_full[56:0];
  end

  // Level index and A-law encoding.
  logic [57:0] ring_num;
  logic [25:0] rb_num;
  logic [7:0]  idx;
  logic        on;
  logic [7:0]  code;

  always_comb begin
    ring_num = {prod_r[56], prod_r} + (58'd255 << 47);
    rb_num   = {s255_r[23], s255_r[23], s255_r} + 26'd8355840;
    if (cfg.tone_kind == TONE_RING) begin
      if (ring_num[57]) idx = '0;
      else if (ring_num[56]) idx = 8'hFF;
      else idx = ring_num[55:48];
      on = (e1_r != '0) && (e2_r != '0);
    end else if (rb_on_r) begin
      if (rb_num[25]) idx = '0;
      else if (rb_num[24]) idx = 8'hFF;
      else idx = rb_num[23:16];
      on = 1'b1;
    end else begin
      idx = 8'd128;
      on  = 1'b0;
    end
    code = alaw_code(idx);
    if (cfg.reverse_bits) code = bit_rev8(code);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      alaw_r <= code;
      on_r   <= on;
    end
  end

  assign out_alaw_sample = alaw_r;
  assign out_tone_on     = on_r;

endmodule

// File: rtl/ttag_ctrl.sv
// Sequencer of the tone generator: steps each sample through the datapath
// and owns both handshakes. Uses ttag_pkg for the command struct.
module ttag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ttag_pkg::ttag_cmd_t cmd
);
  import ttag_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ENV  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       finish;
  logic       accept;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == ST_OUT) && out_free;
  assign in_stall = !((state_r == ST_IDLE) || finish);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_ENV;
      ST_ENV:  state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = accept ? ST_ENV : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign cmd.load       = accept;
  assign cmd.env        = (state_r == ST_ENV);
  assign cmd.mul_first  = (state_r == ST_MUL1);
  assign cmd.mul_second = (state_r == ST_MUL2);
  assign cmd.out_load   = finish;

  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == ST_IDLE || state_r == ST_OUT))
    else $error("request taken while a sample is in progress");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ENV))
    else $error("accepted request did not start the envelope step");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared without a finished sample");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL2) |=> (state_r == ST_OUT))
    else $error("second product not followed by output step");

endmodule

// File: rtl/telephone_tone_alaw_generator.sv
// Top level of the cadenced telephone tone generator with A-law output.
// Instantiates ttag_regs, ttag_ctrl and ttag_datapath; uses ttag_pkg.
//
// Usage: every request on the input channel is one 8 kHz sample tick and
// produces exactly one request on the output channel carrying an A-law byte
// and a flag that tells whether the tone envelope is nonzero for that sample.
// Setting in_restart clears the cadence, warble and phase counters before
// that sample is generated.
// Ring mode plays a 1300 Hz tone in a 4 s cadence with soft edges and a
// warble; ringback mode plays 425 Hz for 1 s out of every 5 s.
// Each sample goes through an envelope and sine ROM read, two passes through
// the single shared multiplier, and the encode step. While a sample is in
// progress, a new request is taken only as it leaves its encode step.
// The output register decouples the channels: while a result waits on a
// stalled receiver, the next request is still taken and worked on; it then
// holds in its encode step until the output register frees, and in_stall
// stays high meanwhile.
// Reset clears the counters, the sequencer and out_valid, and sets tone_kind
// to ring and reverse_bits to one. Registers are to be written over the APB-style
// port only while no sample is in flight; the user must keep to this, the block does not enforce it.
module telephone_tone_alaw_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Sample tick requests.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  // Encoded sample results.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_alaw_sample,
  output logic        out_tone_on,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ttag_pkg::*;

  ttag_cfg_t cfg;
  ttag_cmd_t cmd;

  // Register file: tone kind and output bit order.
  ttag_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer that owns both handshakes.
  ttag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Counters, tables, multiplier and encoder.
  ttag_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_restart      (in_restart),
    .out_alaw_sample (out_alaw_sample),
    .out_tone_on     (out_tone_on)
  );

endmodule

// File: test/tone_sample_checker.sv
// Checker for the cadenced tone generator: watches the request channels and
// the register port, predicts every A-law sample and compares the results.
// Depends on ttag_pkg for the table sizes, register indexes and A-law masks.
module tone_sample_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_alaw_sample,
  input  logic        out_tone_on,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttag_pkg::*;

  localparam int unsigned RING_LEN       = 32000;
  localparam int unsigned RING_ON        = 10400;
  localparam int unsigned RINGBACK_LEN   = 40000;
  localparam int unsigned RINGBACK_FROM  = 16000;
  localparam int unsigned RINGBACK_TO    = 24000;
  localparam int unsigned WARBLE_LEN     = 352;
  localparam int unsigned WARBLE_MID     = 176;
  localparam int unsigned RING_ADVANCE   = (1300 * SINE_TABLE_DEPTH) / 8000;
  localparam int unsigned RINGBACK_ADV   = (425 * SINE_TABLE_DEPTH) / 8000;
  localparam longint      UNIT_Q30       = 64'sd1073741824;
  localparam longint unsigned PI_IN_Q30  = 64'd3373259426;
  localparam int          REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] alaw_sample;
    logic       tone_on;
  } tone_sample_t;

  int          sine_q15   [SINE_TABLE_DEPTH];
  int unsigned edge_fade  [FADE_SAMPLES + 1];
  int unsigned warble_ramp[HALF_FADE + 1];

  // Shadow copies of the registers and the sample counters.
  logic        kind_q;
  logic        flip_q;
  logic [15:0] cadence_pos;
  logic [8:0]  warble_pos;
  logic [8:0]  phase_idx;

  tone_sample_t expected_samples[$];
  int           result_no;

  // sin(2*pi*num/den) in Q30, folded into the first quadrant and summed as
  // a truncated Taylor series in integer steps.
  function automatic longint series_sin(longint unsigned num, longint unsigned den);
    longint unsigned v;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    logic            neg;
    v   = 2 * (num % den);
    neg = 1'b0;
    if (v >= den) begin
      neg = 1'b1;
      v   = v - den;
    end
    if (2 * v > den) v = den - v;
    x    = (PI_IN_Q30 * v) / den;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > UNIT_Q30) acc = UNIT_Q30;
    return neg ? -acc : acc;
  endfunction

  initial begin
    longint s;
    longint m;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      s = series_sin(k, SINE_TABLE_DEPTH);
      m = (s < 0) ? -s : s;
      m = (m + 16384) >> 15;
      if (m > 32767) m = 32767;
      sine_q15[k] = (s < 0) ? -int'(m) : int'(m);
    end
    for (int k = 0; k <= FADE_SAMPLES; k++) begin
      s = series_sin(FADE_SAMPLES + 2 * k, 4 * FADE_SAMPLES);
      edge_fade[k] = int'((UNIT_Q30 - s + 16384) >> 15);
    end
    for (int k = 0; k <= HALF_FADE; k++) begin
      s = series_sin(k, 2 * FADE_SAMPLES);
      warble_ramp[k] = int'((s + 16384) >> 15);
    end
  end

  function automatic int unsigned cadence_env(int unsigned r);
    if (r < FADE_SAMPLES) return edge_fade[r];
    if (r > RING_ON - FADE_SAMPLES && r < RING_ON) return edge_fade[RING_ON - r];
    if (r >= RING_ON) return 0;
    return 65536;
  endfunction

  function automatic int unsigned warble_env(int unsigned r);
    if (r > WARBLE_LEN - HALF_FADE) return 32768 - warble_ramp[WARBLE_LEN - r];
    if (r < HALF_FADE) return 32768 + warble_ramp[r];
    if (r > WARBLE_MID - HALF_FADE && r < WARBLE_MID + HALF_FADE) begin
      if (r >= WARBLE_MID) return 32768 - warble_ramp[r - WARBLE_MID];
      return 32768 + warble_ramp[WARBLE_MID - r];
    end
    if (r <= WARBLE_MID) return 65536;
    return 0;
  endfunction

  function automatic logic [7:0] alaw_encode(int level);
    int         lin;
    int         seg;
    int         mant;
    logic [7:0] flip;
    lin = (level - 128) * 256;
    if (lin >= 0) flip = ALAW_MASK_POS;
    else begin
      flip = ALAW_MASK_NEG;
      lin  = -lin - 8;
    end
    seg = 0;
    while (seg < 8 && lin > (256 << seg) - 1) seg++;
    if (seg == 8) return ALAW_OVF ^ flip;
    mant = (seg < 2) ? ((lin >> 4) & 15) : ((lin >> (seg + 3)) & 15);
    return 8'((seg << 4) | mant) ^ flip;
  endfunction

  // Works out one sample and advances the counters, as the block does for
  // every accepted tick.
  function automatic tone_sample_t next_sample(logic restart);
    tone_sample_t res;
    int unsigned  period;
    int unsigned  advance;
    int unsigned  pos;
    int unsigned  wpos;
    int unsigned  ph;
    int unsigned  env_a;
    int unsigned  env_b;
    longint       prod;
    int           level;
    logic [7:0]   code;
    if (restart) begin
      cadence_pos = '0;
      warble_pos  = '0;
      phase_idx   = '0;
    end
    period  = (kind_q == TONE_RINGBACK) ? RINGBACK_LEN : RING_LEN;
    advance = (kind_q == TONE_RINGBACK) ? RINGBACK_ADV : RING_ADVANCE;
    pos     = (cadence_pos >= period) ? 0 : cadence_pos;
    wpos    = (warble_pos >= WARBLE_LEN) ? 0 : warble_pos;
    ph      = phase_idx % SINE_TABLE_DEPTH;
    if (kind_q == TONE_RING) begin
      env_a = cadence_env(pos);
      env_b = warble_env(wpos);
      prod  = longint'(sine_q15[ph]) * longint'(env_a) * longint'(env_b) * 255
              + (longint'(255) << 47);
      if (prod < 0) prod = 0;
      level       = int'(prod >> 48);
      res.tone_on = (env_a != 0 && env_b != 0);
    end else if (pos >= RINGBACK_FROM && pos < RINGBACK_TO) begin
      prod = longint'(sine_q15[ph]) * 255 + 255 * 32768;
      if (prod < 0) prod = 0;
      level       = int'(prod >> 16);
      res.tone_on = 1'b1;
    end else begin
      level       = 128;
      res.tone_on = 1'b0;
    end
    if (level > 255) level = 255;
    code = alaw_encode(level);
    if (flip_q) begin
      for (int b = 0; b < 8; b++) res.alaw_sample[7 - b] = code[b];
    end else begin
      res.alaw_sample = code;
    end
    cadence_pos = (pos + 1 >= period) ? 16'd0 : 16'(pos + 1);
    warble_pos  = (wpos + 1 >= WARBLE_LEN) ? 9'd0 : 9'(wpos + 1);
    phase_idx   = 9'((ph + advance) % SINE_TABLE_DEPTH);
    return res;
  endfunction

  task automatic note_failure(string what, int exp_v, int got_v);
    if (fail_count < REPORT_LIMIT)
      $display("%0t ns: result %0d: %s expected %0h got %0h",
               $time, result_no, what, exp_v, got_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    result_no  = 0;
  end

  always @(posedge clk) begin : watch
    tone_sample_t got;
    tone_sample_t want;
    if (!rst_n) begin
      kind_q      = TONE_RING;
      flip_q      = 1'b1;
      cadence_pos = '0;
      warble_pos  = '0;
      phase_idx   = '0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TONE_KIND) kind_q = pwdata[0];
        else flip_q = pwdata[0];
      end
      // Results leave before the tick accepted at this edge can produce one.
      if (out_valid && !out_stall) begin
        got.alaw_sample = out_alaw_sample;
        got.tone_on     = out_tone_on;
        if (expected_samples.size() == 0) begin
          note_failure("unexpected result, alaw_sample", 0, got.alaw_sample);
        end else begin
          want = expected_samples.pop_front();
          if (got.alaw_sample !== want.alaw_sample)
            note_failure("alaw_sample", want.alaw_sample, got.alaw_sample);
          if (got.tone_on !== want.tone_on)
            note_failure("tone_on", want.tone_on, got.tone_on);
        end
        result_no++;
      end
      if (in_valid && !in_stall) expected_samples.push_back(next_sample(in_restart));
    end
    pending = expected_samples.size();
  end

endmodule

// File: test/tb_top.sv
// Top of the tone generator testbench: clock, reset, sample tick stimulus,
// receiver stalls and register writes, plus the final verdict.
// Depends on ttag_pkg, telephone_tone_alaw_generator and tone_sample_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ttag_pkg::*;

  // The limit leaves a wide margin over what a correct run needs.
  localparam int CYCLE_LIMIT   = 2000000;
  // Cycles to let pass once nothing more is expected.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  // About one restart in this many ticks during the random part, so most
  // stretches run far enough to cross the warble edges.
  localparam int RESTART_ODDS  = 300;
  // Short full-rate stretches: ringback from a restart stays in the pause
  // before its tone window, and ring carries on from the same counters.
  localparam int RINGBACK_RUN  = 60;
  localparam int RING_RUN      = 70;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_alaw_sample;
  logic        out_tone_on;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_request;

  telephone_tone_alaw_generator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_alaw_sample (out_alaw_sample),
    .out_tone_on     (out_tone_on),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  tone_sample_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_alaw_sample (out_alaw_sample),
    .out_tone_on     (out_tone_on),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Receiver side. It stalls at random with the current percentage, and when
  // asked it holds off for a long stretch so that the block fills up and has
  // to stall its own input while the sender keeps offering requests.
  initial begin
    out_stall    = 1'b0;
    hold_left    = 0;
    hold_request = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one sample tick and returns at the edge where it is accepted.
  // Idle cycles before the request carry random junk on in_restart, which
  // the block must ignore. A request that follows directly keeps in_valid high.
  task automatic send_tick(logic restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  // A run of ticks. With odds above zero a restart comes now and then, so the
  // stream is mostly long well-formed stretches cut at random points.
  task automatic run_ticks(int count, int odds);
    for (int i = 0; i < count; i++)
      send_tick(odds > 0 && $urandom_range(odds - 1) == 0);
  endtask

  // Drops in_valid, then waits until every expected result is in and the
  // pipeline has had time to settle. Everything is sampled at the falling
  // edge, where the checker's count for the last rising edge is final.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready. Only bit 0
  // of each register is meaningful; the upper data bits are random.
  task automatic reg_write(logic reg_idx, logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {31'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mode(logic kind, logic flip);
    wait_idle();
    reg_write(REG_TONE_KIND, kind);
    reg_write(REG_REVERSE_BITS, flip);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_restart    = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset settings (ring tone, reversed
    // bytes): a restart at the very first tick, a few ticks from the top of
    // the cadence, and back-to-back restarts.
    send_tick(1'b1);
    run_ticks(4, 0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    // Plain byte order.
    wait_idle();
    reg_write(REG_REVERSE_BITS, 1'b0);
    run_ticks(3, 0);
    // Ringback without a restart: the counters carry over, and the start of
    // the ringback cadence is a pause at the middle level.
    wait_idle();
    reg_write(REG_TONE_KIND, TONE_RINGBACK);
    run_ticks(3, 0);
    send_tick(1'b1);
    wait_idle();
    reg_write(REG_REVERSE_BITS, 1'b1);
    run_ticks(2, 0);
    // Back to ring mid-cadence: the warble position moved on in ringback.
    wait_idle();
    reg_write(REG_TONE_KIND, TONE_RING);
    run_ticks(2, 0);

    // Random part, first with a busy receiver, then with a sparse sender.
    send_idle_pct = 13;
    recv_idle_pct = 60;
    set_mode(TONE_RING, 1'b0);
    run_ticks(500, RESTART_ODDS);

    send_idle_pct = 60;
    recv_idle_pct = 13;
    set_mode(TONE_RINGBACK, 1'b1);
    run_ticks(500, RESTART_ODDS);

    // No idling on either side, opened by one long receiver hold-off while
    // requests keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(TONE_RING, 1'b1);
    hold_request = 1'b1;
    run_ticks(500, RESTART_ODDS);

    // Short stretches at full rate: ringback from a restart, then ring
    // continuing from the counters that ringback left behind.
    set_mode(TONE_RINGBACK, 1'b0);
    send_tick(1'b1);
    run_ticks(RINGBACK_RUN, 0);
    wait_idle();
    reg_write(REG_TONE_KIND, TONE_RING);
    run_ticks(RING_RUN, 0);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ttag_pkg.sv
rtl/ttag_regs.sv
rtl/ttag_datapath.sv
rtl/ttag_ctrl.sv
rtl/telephone_tone_alaw_generator.sv
test/tone_sample_checker.sv
test/tb_top.sv
